### rtl/rbt_pkg.sv
// ----------------------------------------------------------------------------
// rbt_pkg : shared types and constants for the radiance to brightness unit
// Row layout, operation / mode / status codes, divider request bundle.
// ----------------------------------------------------------------------------
package rbt_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   // one table row: {ch5, ch4, ch3, temperature}, temperature lowest
   localparam int ROW_W = 128;

   localparam int DIV_NUM_W = 89;
   localparam int DIV_DEN_W = 64;

   localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
   localparam logic [31:0] PI100_Q16    = 32'd20588742;
   localparam logic [15:0] NIGHT_ZENITH = 16'd23040;   // 90.0 deg, Q8.8
   localparam logic [31:0] KM_TO_M      = 32'd1000;

   typedef enum logic [1:0] {
      OP_CONVERT = 2'd0,
      OP_WRITE   = 2'd1,
      OP_FINISH  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [2:0] MODE_PASS = 3'd0;
   localparam logic [2:0] MODE_VIS  = 3'd1;
   localparam logic [2:0] MODE_CH3  = 3'd2;
   localparam logic [2:0] MODE_CH4  = 3'd3;
   localparam logic [2:0] MODE_CH5  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_TABLE = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_GEOMETRY = 2'd3;

   localparam logic [1:0] CSR_SOLAR_IRR = 2'd0;
   localparam logic [1:0] CSR_MEAN_DIST = 2'd1;
   localparam logic [1:0] CSR_ALB_LIMIT = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   function automatic logic [31:0] row_temp(input logic [ROW_W-1:0] row);
      return row[31:0];
   endfunction

   function automatic logic [31:0] row_col(input logic [ROW_W-1:0] row,
                                           input logic [2:0] mode);
      logic [31:0] c;
      case (mode)
         MODE_CH3: c = row[63:32];
         MODE_CH4: c = row[95:64];
         default:  c = row[127:96];
      endcase
      return c;
   endfunction

endpackage

### rtl/radiance_to_brightness_temp_unit.sv
// ----------------------------------------------------------------------------
// radiance_to_brightness_temp_unit : radiance to brightness temperature
// Calibration table in one RAM, bisection search, linear interpolation,
// visible albedo path; one shared 32x32 multiplier and one serial divider.
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  req_*    | in        | table writes, table finish, conversion requests
//  rsp_*    | out       | one result per conversion (value, status)
//  csr_*    | in        | irradiance, mean sun distance, albedo limit
//
// Sequencing: a write reads the row below, then checks order and stores it;
//   infrared reads the end rows, checks the range, bisects and waits on the
//   divider unless a row matches exactly; visible runs the multiplier
//   sequence with up to two divider waits.
// One item at a time; req_tready is high only in the idle state. A result
//   waits in the rsp register while the next item is taken in.
// Reset clears control and table flags and loads default configuration;
//   table contents are left as they are and no clearing pass is run.
// A stalled rsp side holds the sequencer in its output state.
//
module radiance_to_brightness_temp_unit
   import rbt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   // [8:0] row_index, [40:9] row_temperature, [72:41] row_radiance_ch3,
   // [104:73] row_radiance_ch4, [136:105] row_radiance_ch5,
   // [168:137] radiance, [208:169] sun_distance_m, [224:209] zenith_angle,
   // [240:225] cos_zenith, [241] geometry_missing, [247:242] zero
   input  logic [247:0] req_tdata,
   // [1:0] operation, [4:2] conversion_mode
   input  logic [4:0]   req_tuser,
   // result
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] value
   output logic [31:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   // configuration
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   typedef enum logic [25:0] {
      S_IDLE   = 26'h0000001,
      S_WR_RD  = 26'h0000002,
      S_WR_CHK = 26'h0000004,
      S_IR_A   = 26'h0000008,
      S_IR_B   = 26'h0000010,
      S_IR_C   = 26'h0000020,
      S_BS_RD  = 26'h0000040,
      S_BS_CMP = 26'h0000080,
      S_IF0    = 26'h0000100,
      S_IF1    = 26'h0000200,
      S_IDIV   = 26'h0000400,
      S_VM0    = 26'h0000800,
      S_VM1    = 26'h0001000,
      S_VM2    = 26'h0002000,
      S_VQ     = 26'h0004000,
      S_VM3    = 26'h0008000,
      S_VM4    = 26'h0010000,
      S_VM5    = 26'h0020000,
      S_VM6    = 26'h0040000,
      S_VM7    = 26'h0080000,
      S_VM8    = 26'h0100000,
      S_VM9    = 26'h0200000,
      S_VM10   = 26'h0400000,
      S_VDIV   = 26'h0800000,
      S_OUT    = 26'h1000000
   } state_type;

   state_type state_ff, state_in;

   // request fields
   logic [8:0]       f_idx;
   logic [ROW_W-1:0] f_row;
   logic [31:0]      f_x;
   logic [39:0]      f_dist;
   logic [15:0]      f_zen;
   logic [15:0]      f_cos;
   logic             f_geo;
   op_type           f_op;
   logic [2:0]       f_mode;

   assign f_idx  = req_tdata[8:0];
   assign f_row  = {req_tdata[136:105], req_tdata[104:73], req_tdata[72:41],
                    req_tdata[40:9]};
   assign f_x    = req_tdata[168:137];
   assign f_dist = req_tdata[208:169];
   assign f_zen  = req_tdata[224:209];
   assign f_cos  = req_tdata[240:225];
   assign f_geo  = req_tdata[241];
   assign f_op   = op_type'(req_tuser[1:0]);
   assign f_mode = req_tuser[4:2];

   logic req_xfer;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // held item
   logic [8:0]       idx_ff, idx_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [31:0]      x_ff, x_in;
   logic [39:0]      dist_ff, dist_in;
   logic [15:0]      cos_ff, cos_in;
   logic [2:0]       mode_ff, mode_in;

   // table flags and configuration
   logic [8:0]  count_ff, count_in;
   logic        tvalid_ff, tvalid_in;
   logic        oerr_ff, oerr_in;
   logic [31:0] irr_ff, irr_in;
   logic [27:0] mdist_ff, mdist_in;
   logic [31:0] alim_ff, alim_in;

   // search and arithmetic
   logic [AW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [ROW_W-1:0] lo_row_ff, lo_row_in, hi_row_ff, hi_row_in;
   logic [31:0]      dr_ff, dr_in;
   logic             neg_ff, neg_in;
   logic [63:0]      den_ff, den_in, den2_ff, den2_in;
   logic [31:0]      q_ff, q_in, q2_ff, q2_in;
   logic [63:0]      n1_ff, n1_in, acc_ff, acc_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p_ff;

   logic [31:0] res_val_ff, res_val_in;
   logic [1:0]  res_st_ff, res_st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;

   // RAM
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [ROW_W-1:0] ram_rdata;

   // divider
   div_req_type div_req;
   logic        div_done;
   logic [31:0] div_quot;

   rbt_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (row_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rbt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // helpers
   logic [AW:0]   mid_sum;
   logic [AW-1:0] span;
   logic [31:0]   c_lo, c_hi, c_rd, t_lo, t_hi;
   logic [8:0]    count_m1;
   logic [27:0]   mdist_eff;
   logic [31:0]   alb_q;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign span      = hi_ff - lo_ff;
   assign c_lo      = row_col(lo_row_ff, mode_ff);
   assign c_hi      = row_col(hi_row_ff, mode_ff);
   assign c_rd      = row_col(ram_rdata, mode_ff);
   assign t_lo      = row_temp(lo_row_ff);
   assign t_hi      = row_temp(hi_row_ff);
   assign count_m1  = count_ff - 9'd1;
   assign mdist_eff = (mdist_ff == 28'd0) ? 28'd1 : mdist_ff;
   assign alb_q     = (div_quot > alim_ff) ? alim_ff : div_quot;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VM0: begin
            mul_a = {4'd0, mdist_eff};
            mul_b = KM_TO_M;
         end
         S_VM1: begin
            mul_a = irr_ff;
            mul_b = {16'd0, cos_ff};
         end
         S_VM3: begin
            mul_a = q_ff;
            mul_b = q_ff;
         end
         S_VM5: begin
            mul_a = x_ff;
            mul_b = q2_ff;
         end
         S_VM7: begin
            mul_a = n1_ff[31:0];
            mul_b = PI100_Q16;
         end
         S_VM8: begin
            mul_a = n1_ff[63:32];
            mul_b = PI100_Q16;
         end
         S_IF0: begin
            mul_a = x_ff - c_hi;
            mul_b = (t_lo >= t_hi) ? (t_lo - t_hi) : (t_hi - t_lo);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      x_in       = x_ff;
      dist_in    = dist_ff;
      cos_in     = cos_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      tvalid_in  = tvalid_ff;
      oerr_in    = oerr_ff;
      irr_in     = irr_ff;
      mdist_in   = mdist_ff;
      alim_in    = alim_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      lo_row_in  = lo_row_ff;
      hi_row_in  = hi_row_ff;
      dr_in      = dr_ff;
      neg_in     = neg_ff;
      den_in     = den_ff;
      den2_in    = den2_ff;
      q_in       = q_ff;
      q2_in      = q2_ff;
      n1_in      = n1_ff;
      acc_in     = acc_ff;
      num_in     = num_ff;
      res_val_in = res_val_ff;
      res_st_in  = res_st_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = AW'(idx_ff);
      ram_raddr  = '0;
      div_req    = '0;

      rsp_valid_in = rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_SOLAR_IRR: irr_in   = csr_data;
            CSR_MEAN_DIST: mdist_in = csr_data[27:0];
            CSR_ALB_LIMIT: alim_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               idx_in     = f_idx;
               row_in     = f_row;
               x_in       = f_x;
               dist_in    = f_dist;
               cos_in     = f_cos;
               mode_in    = f_mode;
               res_val_in = '0;
               res_st_in  = ST_OK;
               case (f_op)
                  OP_WRITE: begin
                     if ({23'd0, f_idx} < 32'(TABLE_DEPTH)) begin
                        state_in = S_WR_RD;
                     end
                  end
                  OP_FINISH: begin
                     count_in  = f_idx;
                     tvalid_in = !oerr_ff && (f_idx >= 9'd2) &&
                                 ({23'd0, f_idx} <= 32'(TABLE_DEPTH));
                  end
                  OP_CONVERT: begin
                     if (f_mode == MODE_PASS) begin
                        res_val_in = f_x;
                        state_in   = S_OUT;
                     end else if (f_mode == MODE_VIS) begin
                        if (f_geo) begin
                           res_st_in = ST_GEOMETRY;
                           state_in  = S_OUT;
                        end else if (f_zen > NIGHT_ZENITH) begin
                           state_in = S_OUT;
                        end else begin
                           state_in = S_VM0;
                        end
                     end else if (f_mode inside {MODE_CH3, MODE_CH4, MODE_CH5}) begin
                        if (!tvalid_ff) begin
                           res_st_in = ST_NO_TABLE;
                           state_in  = S_OUT;
                        end else begin
                           state_in = S_IR_A;
                        end
                     end else begin
                        res_st_in = ST_RANGE;
                        state_in  = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // table load: fetch the row below, then check order and store
         S_WR_RD: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_ff - 9'd1);
            state_in  = S_WR_CHK;
         end
         S_WR_CHK: begin
            ram_we    = 1'b1;
            tvalid_in = 1'b0;
            if (idx_ff == 9'd0) begin
               oerr_in = 1'b0;
            end else if (row_ff[31:0] > ram_rdata[31:0] ||
                         row_ff[63:32] > ram_rdata[63:32] ||
                         row_ff[95:64] > ram_rdata[95:64] ||
                         row_ff[127:96] > ram_rdata[127:96]) begin
               oerr_in = 1'b1;
            end
            state_in = S_IDLE;
         end

         // infrared: end rows, range check, bisection
         S_IR_A: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_in  = S_IR_B;
         end
         S_IR_B: begin
            lo_row_in = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = AW'(count_m1);
            state_in  = S_IR_C;
         end
         S_IR_C: begin
            if (x_ff > c_lo || x_ff < c_rd) begin
               res_st_in = ST_RANGE;
               state_in  = S_OUT;
            end else begin
               hi_row_in = ram_rdata;
               lo_in     = '0;
               hi_in     = AW'(count_m1);
               state_in  = S_BS_RD;
            end
         end
         S_BS_RD: begin
            if (span > AW'(1)) begin
               mid_in    = mid_sum[AW:1];
               ram_re    = 1'b1;
               ram_raddr = mid_sum[AW:1];
               state_in  = S_BS_CMP;
            end else begin
               state_in = S_IF0;
            end
         end
         S_BS_CMP: begin
            if (c_rd >= x_ff) begin
               lo_in     = mid_ff;
               lo_row_in = ram_rdata;
            end else begin
               hi_in     = mid_ff;
               hi_row_in = ram_rdata;
            end
            state_in = S_BS_RD;
         end
         S_IF0: begin
            if (c_lo == x_ff) begin
               res_val_in = t_lo;
               state_in   = S_OUT;
            end else if (c_hi == x_ff) begin
               res_val_in = t_hi;
               state_in   = S_OUT;
            end else begin
               dr_in    = c_lo - c_hi;
               neg_in   = t_lo < t_hi;
               state_in = S_IF1;
            end
         end
         S_IF1: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(mul_p_ff);
            div_req.den   = DIV_DEN_W'(dr_ff);
            state_in      = S_IDIV;
         end
         S_IDIV: begin
            if (div_done) begin
               res_val_in = neg_ff ? (t_hi - div_quot) : (t_hi + div_quot);
               state_in   = S_OUT;
            end
         end

         // visible: q = d*2^16/(M*1000), q2 = q*q>>16, albedo = R*q2*pi100/(2IC)
         S_VM0: state_in = S_VM1;
         S_VM1: begin
            den_in   = mul_p_ff;
            state_in = S_VM2;
         end
         S_VM2: begin
            den2_in       = {mul_p_ff[62:0], 1'b0};
            div_req.start = 1'b1;
            div_req.num   = {33'd0, dist_ff, 16'd0};
            div_req.den   = den_ff;
            state_in      = S_VQ;
         end
         S_VQ: begin
            if (div_done) begin
               q_in     = div_quot;
               state_in = S_VM3;
            end
         end
         S_VM3: state_in = S_VM4;
         S_VM4: begin
            q2_in    = (mul_p_ff[63:48] != 16'd0) ? MAX32 : mul_p_ff[47:16];
            state_in = S_VM5;
         end
         S_VM5: state_in = S_VM6;
         S_VM6: begin
            n1_in    = mul_p_ff;
            state_in = S_VM7;
         end
         S_VM7: state_in = S_VM8;
         S_VM8: begin
            acc_in   = mul_p_ff;
            state_in = S_VM9;
         end
         S_VM9: begin
            num_in   = {mul_p_ff[56:0], 32'd0} + DIV_NUM_W'(acc_ff);
            state_in = S_VM10;
         end
         S_VM10: begin
            if (den2_ff == 64'd0) begin
               // no irradiance or cosine: saturate unless the numerator is zero
               res_val_in = (n1_ff != 64'd0) ? alim_ff : 32'd0;
               state_in   = S_OUT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = num_ff;
               div_req.den   = den2_ff;
               state_in      = S_VDIV;
            end
         end
         S_VDIV: begin
            if (div_done) begin
               res_val_in = alb_q;
               state_in   = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         tvalid_ff    <= 1'b0;
         oerr_ff      <= 1'b0;
         irr_ff       <= 32'd11020534;
         mdist_ff     <= 28'd149597870;
         alim_ff      <= 32'd6553600;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         tvalid_ff    <= tvalid_in;
         oerr_ff      <= oerr_in;
         irr_ff       <= irr_in;
         mdist_ff     <= mdist_in;
         alim_ff      <= alim_in;
      end
      idx_ff     <= idx_in;
      row_ff     <= row_in;
      x_ff       <= x_in;
      dist_ff    <= dist_in;
      cos_ff     <= cos_in;
      mode_ff    <= mode_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      lo_row_ff  <= lo_row_in;
      hi_row_ff  <= hi_row_in;
      dr_ff      <= dr_in;
      neg_ff     <= neg_in;
      den_ff     <= den_in;
      den2_ff    <= den2_in;
      q_ff       <= q_in;
      q2_ff      <= q2_in;
      n1_ff      <= n1_in;
      acc_ff     <= acc_in;
      num_ff     <= num_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
      mul_p_ff   <= mul_a * mul_b;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_st_ff;

   // divider completes only while the sequencer is waiting on it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_IDIV || state_ff == S_VQ || state_ff == S_VDIV))
      else $error("divider result with no waiting state");

   // a valid table always holds a usable bracket
   a_table_count: assert property (@(posedge clock) disable iff (reset)
      tvalid_ff |-> (count_ff >= 9'd2))
      else $error("table valid with fewer than two rows");

   // probe stays strictly inside the bracket
   a_bisect_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BS_CMP) |-> (lo_ff < mid_ff && mid_ff < hi_ff))
      else $error("bisection probe outside bracket");

   // a new result is only ever launched from the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result launched outside output state");

endmodule

### rtl/rbt_ram.sv
// ----------------------------------------------------------------------------
// rbt_ram : simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rbt_div.sv
// ----------------------------------------------------------------------------
// rbt_div : restoring divider, 32-bit saturated quotient
// One quotient bit per cycle; quotient of 2^32 or more saturates at once.
// ----------------------------------------------------------------------------
module rbt_div
   import rbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [31:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [31:0]          low_ff, low_in;
   logic [31:0]          quot_ff, quot_in;

   logic [DIV_DEN_W:0]   rem2;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;
   logic                 sat;

   assign rem2 = {rem_ff, low_ff[31]};
   assign fits = rem2 >= {1'b0, den_ff};
   assign diff = rem2 - {1'b0, den_ff};
   // high part already at or above the divisor: quotient overflows 32 bits
   assign sat  = {7'd0, req.num[DIV_NUM_W-1:32]} >= req.den;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      if (req.start) begin
         den_in = req.den;
         if (sat) begin
            quot_in = MAX32;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {7'd0, req.num[DIV_NUM_W-1:32]};
            low_in  = req.num[31:0];
            quot_in = '0;
            cnt_in  = 6'd32;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];
         low_in  = {low_ff[30:0], 1'b0};
         quot_in = {quot_ff[30:0], fits};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
